@@ rtl/core/video_port_vram_access_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the video port block
// Same-cycle and next-cycle implication checks, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VIDEO_PORT_VRAM_ACCESS_TOP_DEFINES_SVH
`define VIDEO_PORT_VRAM_ACCESS_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define VPVA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vpva check failed");

// antecedent implies consequent in the next cycle
`define VPVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vpva check failed");

`endif

@@ rtl/core/vpva_pkg.sv @@
// ----------------------------------------------------------------------------
// vpva_pkg
// Shared constants, codes and types of the video port block.
// ----------------------------------------------------------------------------
package vpva_pkg;

    localparam int VRAM_DEPTH    = 16384;
    localparam int PALETTE_DEPTH = 32;
    localparam int VRAM_AW       = $clog2(VRAM_DEPTH);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int ADDR_W        = 14;

    // bus access kinds
    localparam logic [1:0] FUNC_CTRL  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // second control byte action codes
    localparam logic [1:0] CODE_PREFETCH = 2'd0;
    localparam logic [1:0] CODE_PALETTE  = 2'd3;

    typedef struct packed {
        logic               we;
        logic               re;
        logic [VRAM_AW-1:0] addr;
        logic [7:0]         wdata;
    } vram_req_t;

    // address modulo a power-of-two depth
    function automatic logic [VRAM_AW-1:0] vram_index(input logic [ADDR_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[VRAM_AW-1:0];
    endfunction

    function automatic logic [PAL_AW-1:0] pal_index(input logic [ADDR_W-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[PAL_AW-1:0];
    endfunction

endpackage

@@ rtl/core/video_port_vram_access_top.sv @@
// ----------------------------------------------------------------------------
// video_port_vram_access_top
// Control and data port of a video chip: address setup, video memory and
// palette writes, buffered video memory reads.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one bus access per item, func selects
//   control write, data write or data read; data_byte carries the byte.
//   Output channel (out_valid / out_stall): one result per item with the read
//   byte (zero unless a data read), the address after the access and the
//   current write target (palette or video memory).
//   Flow: an accepted item goes to the execute state and from there into the
//   output register, a step that a receiver stall can hold back.
//   Accept: no new item is taken while in the execute state, where the single
//   video memory port's registered read data refills the read buffer.
//   Reset: address, pending flag, target and read buffer clear at once; the
//   video memory is zeroed by a sweep over all 16384 entries, one entry per cycle,
//   during which in_stall is high.
//   Receiver stall: the result stays in the output register; one further item
//   can be accepted, then it waits in the execute state with in_stall high
//   until the output register frees up.
// ----------------------------------------------------------------------------
`include "video_port_vram_access_top_defines.svh"

module video_port_vram_access_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  func,
    input  logic [7:0]                  data_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  read_data,
    output logic [vpva_pkg::ADDR_W-1:0] cur_address,
    output logic                        palette_target
);
    import vpva_pkg::*;

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] address_reg, address_next;
    logic              pending_reg, pending_next;
    logic              pal_sel_reg, pal_sel_next;
    logic [7:0]        rbuf_reg;
    logic              load_buf_reg, load_buf_next;
    logic [7:0]        rd_hold_reg, rd_hold_next;
    logic              out_valid_reg;
    logic [7:0]        out_rd_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_pal_reg;

    logic              accept;
    logic              out_free;
    logic              pal_we;
    vram_req_t         vreq, vreq_raw;
    logic [7:0]        vram_rdata;
    logic              clear_busy;

    logic [7:0]        palette_mem [PALETTE_DEPTH];

    assign in_stall = clear_busy || (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        address_next  = address_reg;
        pending_next  = pending_reg;
        pal_sel_next  = pal_sel_reg;
        load_buf_next = 1'b0;
        rd_hold_next  = 8'h00;
        pal_we        = 1'b0;
        vreq_raw      = '0;
        vreq_raw.addr  = vram_index(address_reg);
        vreq_raw.wdata = data_byte;
        case (func)
            FUNC_CTRL:
            begin
                if (!pending_reg)
                begin
                    address_next = ADDR_W'(data_byte);
                    pending_next = 1'b1;
                end
                else
                begin
                    pending_next = 1'b0;
                    address_next = address_reg | {data_byte[5:0], 8'h00};
                    case (data_byte[7:6])
                        CODE_PREFETCH:
                        begin
                            pal_sel_next  = 1'b0;
                            load_buf_next = 1'b1;
                            vreq_raw.re   = 1'b1;
                            vreq_raw.addr = vram_index(address_next);
                        end
                        CODE_PALETTE: pal_sel_next = 1'b1;
                        default:      pal_sel_next = 1'b0;
                    endcase
                end
            end
            FUNC_WRITE:
            begin
                if (pal_sel_reg)
                begin
                    pal_we = 1'b1;
                end
                else
                begin
                    vreq_raw.we = 1'b1;
                end
                address_next = address_reg + 1'b1;
            end
            FUNC_READ:
            begin
                rd_hold_next  = rbuf_reg;
                load_buf_next = 1'b1;
                vreq_raw.re   = 1'b1;
                address_next  = address_reg + 1'b1;
            end
            default: ;
        endcase
        vreq    = vreq_raw;
        vreq.we = vreq_raw.we && accept;
        vreq.re = vreq_raw.re && accept;
    end

    vpva_vram u_vram (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (vreq),
        .rdata      (vram_rdata),
        .clear_busy (clear_busy)
    );

    always_ff @(posedge clk)
    begin
        if (accept && pal_we)
        begin
            palette_mem[pal_index(address_reg)] <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            address_reg   <= '0;
            pending_reg   <= 1'b0;
            pal_sel_reg   <= 1'b0;
            rbuf_reg      <= 8'h00;
            load_buf_reg  <= 1'b0;
            rd_hold_reg   <= 8'h00;
            out_valid_reg <= 1'b0;
            out_rd_reg    <= 8'h00;
            out_addr_reg  <= '0;
            out_pal_reg   <= 1'b0;
        end
        else
        begin
            // in the execute state the output register is handled below
            if (out_valid_reg && !out_stall && (state_reg != ST_EXEC))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        address_reg  <= address_next;
                        pending_reg  <= pending_next;
                        pal_sel_reg  <= pal_sel_next;
                        load_buf_reg <= load_buf_next;
                        rd_hold_reg  <= rd_hold_next;
                        state_reg    <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    // ram read data holds until the next read, so waiting is safe
                    if (out_free)
                    begin
                        if (load_buf_reg)
                        begin
                            rbuf_reg <= vram_rdata;
                        end
                        out_valid_reg <= 1'b1;
                        out_rd_reg    <= rd_hold_reg;
                        out_addr_reg  <= address_reg;
                        out_pal_reg   <= pal_sel_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = out_rd_reg;
    assign cur_address    = out_addr_reg;
    assign palette_target = out_pal_reg;

    `VPVA_ASSERT_NOW(a_no_accept_in_clear, clk, rst_n, clear_busy, in_stall)
    `VPVA_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, state_reg == ST_EXEC)
    `VPVA_ASSERT_NEXT(a_exec_delivers, clk, rst_n, (state_reg == ST_EXEC) && out_free, out_valid_reg && (state_reg == ST_IDLE))
    `VPVA_ASSERT_NOW(a_no_vram_access_in_clear, clk, rst_n, clear_busy, !vreq.we && !vreq.re)

endmodule

@@ rtl/core/vpva_vram.sv @@
// ----------------------------------------------------------------------------
// vpva_vram
// Video memory, one port, registered read data, zero sweep after reset.
// ----------------------------------------------------------------------------
module vpva_vram (
    input  logic                clk,
    input  logic                rst_n,
    input  vpva_pkg::vram_req_t req,
    output logic [7:0]          rdata,
    output logic                clear_busy
);
    import vpva_pkg::*;

    logic [7:0]         mem [VRAM_DEPTH];
    logic [7:0]         rdata_reg;
    logic [VRAM_AW-1:0] clr_cnt_reg;
    logic               busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else if (busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == VRAM_AW'(VRAM_DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_cnt_reg] <= 8'h00;
        end
        else if (req.we)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = busy_reg;

endmodule

@@ bench/tb_video_port_vram_access_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for video_port_vram_access_top
// Drives control, data write and data read accesses through the input
// channel, predicts address, buffer and target state in a shadow copy of
// the port logic, and checks every result item against it.
// ----------------------------------------------------------------------------
module tb_video_port_vram_access_top;

    import vpva_pkg::*;

    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam logic [1:0] CODE_VRAM_WR   = 2'd1;
    localparam logic [1:0] CODE_REG_WR    = 2'd2;
    localparam int         WATCHDOG_LIMIT = 60000;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [ADDR_W-1:0] address;
        logic              palette;
    } port_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        func = FUNC_CTRL;
    logic [7:0]        data_byte = 8'd0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        read_data;
    logic [ADDR_W-1:0] cur_address;
    logic              palette_target;

    // shadow of the port state
    logic [ADDR_W-1:0] shadow_addr;
    logic              shadow_pending;
    logic              shadow_pal;
    logic [7:0]        shadow_rbuf;
    logic [7:0]        shadow_vram [VRAM_DEPTH];

    port_result_t      expected_results[$];

    int sent_count, checked_count, mismatch_count;
    int n_writes, n_pal_writes, n_reads, n_prefetch, n_wraps, n_ignored;
    int burst_left, idle_cycles, stall_tick, stall_mode;

    video_port_vram_access_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .cur_address    (cur_address),
        .palette_target (palette_target)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void step_address();
        if (shadow_addr == '1)
            n_wraps++;
        shadow_addr = shadow_addr + 1'b1;
    endfunction

    function automatic void predict_access(input logic [1:0] f, input logic [7:0] b);
        port_result_t res;
        res.read_data = 8'd0;
        case (f)
            FUNC_CTRL:
            begin
                if (!shadow_pending)
                begin
                    shadow_addr    = {6'd0, b};
                    shadow_pending = 1'b1;
                end
                else
                begin
                    shadow_pending = 1'b0;
                    shadow_addr    = shadow_addr | {b[5:0], 8'd0};
                    if (b[7:6] == CODE_PREFETCH)
                    begin
                        shadow_pal  = 1'b0;
                        shadow_rbuf = shadow_vram[int'(shadow_addr) % VRAM_DEPTH];
                        n_prefetch++;
                    end
                    else
                        shadow_pal = (b[7:6] == CODE_PALETTE);
                end
            end
            FUNC_WRITE:
            begin
                // palette contents are never visible at the ports
                if (shadow_pal)
                    n_pal_writes++;
                else
                    shadow_vram[int'(shadow_addr) % VRAM_DEPTH] = b;
                n_writes++;
                step_address();
            end
            FUNC_READ:
            begin
                res.read_data = shadow_rbuf;
                shadow_rbuf   = shadow_vram[int'(shadow_addr) % VRAM_DEPTH];
                n_reads++;
                step_address();
            end
            default:
                n_ignored++;
        endcase
        res.address = shadow_addr;
        res.palette = shadow_pal;
        expected_results.push_back(res);
    endfunction

    // One item; valid stays high into the next item unless a gap is drawn
    // or this is the last item before a pause.
    task automatic send_access(input logic [1:0] f, input logic [7:0] b,
                               input bit last = 1'b0);
        int gap;
        in_valid  <= 1'b1;
        func      <= f;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_access(f, b);
        sent_count++;
        if (last)
            in_valid <= 1'b0;
        else if (burst_left > 0)
            burst_left--;
        else
        begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 20);
                default: gap = $urandom_range(1, 4);
            endcase
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // address extremes, wrap, every action code, func 3, data access and
    // read between the two control bytes, prefetch then reads
    task automatic test_directed_corners();
        send_access(FUNC_READ, 8'h00);
        send_access(FUNC_CTRL, 8'hFF);
        send_access(FUNC_WRITE, 8'hA5);
        send_access(FUNC_CTRL, 8'h7F);
        send_access(FUNC_CTRL, 8'hFF);
        send_access(FUNC_CTRL, {CODE_VRAM_WR, 6'h3F});
        send_access(FUNC_WRITE, 8'h00);
        send_access(FUNC_WRITE, 8'hFF);
        send_access(FUNC_CTRL, 8'hFF);
        send_access(FUNC_CTRL, {CODE_REG_WR, 6'h3F});
        send_access(FUNC_WRITE, 8'h5A);
        send_access(FUNC_CTRL, 8'hFF);
        send_access(FUNC_CTRL, {CODE_PREFETCH, 6'h3F});
        send_access(FUNC_READ, 8'hFF);
        send_access(FUNC_READ, 8'h00);
        send_access(FUNC_READ, 8'h55);
        send_access(FUNC_CTRL, 8'h00);
        send_access(FUNC_CTRL, {CODE_PALETTE, 6'h00});
        send_access(FUNC_WRITE, 8'h12);
        send_access(FUNC_UNUSED, 8'hFF);
        send_access(FUNC_CTRL, 8'h1F);
        send_access(FUNC_CTRL, {CODE_PALETTE, 6'h3F});
        send_access(FUNC_WRITE, 8'hEE);
        send_access(FUNC_CTRL, 8'h10);
        send_access(FUNC_READ, 8'hAA);
        send_access(FUNC_CTRL, {CODE_PREFETCH, 6'h00});
    endtask

    task automatic test_random_traffic(input int n_items);
        int stop_at, kind, run_len, sel;
        logic [ADDR_W-1:0] addr;
        logic [1:0] code;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // address setup, then a run of data accesses
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    addr = ADDR_W'($urandom_range(0, 95));
                else if (sel < 8)
                    addr = ADDR_W'($urandom_range(16'h3FC0, 16'h3FFF));
                else
                    addr = ADDR_W'($urandom_range(0, 16'h3FFF));
                code = 2'($urandom_range(0, 3));
                send_access(FUNC_CTRL, addr[7:0]);
                send_access(FUNC_CTRL, {code, addr[13:8]});
                run_len = $urandom_range(1, 12);
                repeat (run_len)
                begin
                    if (code == CODE_PALETTE || (code != CODE_PREFETCH && $urandom_range(0, 1)))
                        send_access(FUNC_WRITE, 8'($urandom_range(0, 255)));
                    else
                        send_access(FUNC_READ, 8'($urandom_range(0, 255)));
                end
            end
            else if (kind < 85)
            begin
                run_len = $urandom_range(1, 8);
                repeat (run_len)
                    send_access($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
                                8'($urandom_range(0, 255)));
            end
            else if (kind < 95)
                send_access(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            else
                send_access(FUNC_UNUSED, 8'($urandom_range(0, 255)));
        end
    endtask

    // sender holds off until the output side has caught up completely
    task automatic test_drain_pause();
        send_access(FUNC_CTRL, 8'h20);
        send_access(FUNC_CTRL, {CODE_PREFETCH, 6'h00});
        send_access(FUNC_READ, 8'h00);
        send_access(FUNC_READ, 8'h00, 1'b1);
        wait_results_drained();
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin : result_check
        port_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            checked_count++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: read_data %0h cur_address %0h palette_target %0b",
                       read_data, cur_address, palette_target);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %0h, got %0h", want.read_data, read_data);
                    mismatch_count++;
                end
                if (cur_address !== want.address)
                begin
                    $error("cur_address: expected %0h, got %0h", want.address, cur_address);
                    mismatch_count++;
                end
                if (palette_target !== want.palette)
                begin
                    $error("palette_target: expected %0b, got %0b",
                           want.palette, palette_target);
                    mismatch_count++;
                end
            end
        end
        stall_tick++;
        if (stall_tick % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (stall_tick % 8 < 3);
        endcase
    end

    // covers the video memory clear sweep after reset as well
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("** video_port_vram_access_top: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        shadow_addr    = '0;
        shadow_pending = 1'b0;
        shadow_pal     = 1'b0;
        shadow_rbuf    = 8'd0;
        foreach (shadow_vram[i])
            shadow_vram[i] = 8'd0;
        burst_left = 0;
        stall_mode = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_traffic(700);
        test_drain_pause();
        test_random_traffic(800);
        send_access(FUNC_READ, 8'h00, 1'b1);

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            mismatch_count++;
        end
        $display("Sent %0d accesses: %0d data writes (%0d to palette), %0d reads, %0d prefetches",
                 sent_count, n_writes, n_pal_writes, n_reads, n_prefetch);
        $display("%0d address wraps, %0d unused-func accesses, %0d results checked",
                 n_wraps, n_ignored, checked_count);
        if (mismatch_count == 0)
            $display("** video_port_vram_access_top: PASSED **");
        else
            $display("** video_port_vram_access_top: FAILED **");
        $finish;
    end

endmodule

@@ video_port_vram_access_top.f @@
+incdir+rtl/core
rtl/core/vpva_pkg.sv
rtl/core/vpva_vram.sv
rtl/core/video_port_vram_access_top.sv
bench/tb_video_port_vram_access_top.sv
